/* rtl/core/smi_pkg.sv */
// Package for the sorted multiset intersection core: payload structs,
// mode codes and the command and status structs of the sorting chains.
// No dependencies.
`default_nettype none

package smi_pkg;

    localparam int VALUE_W = 32;
    localparam int MODE_W  = 2;

    typedef logic signed [VALUE_W-1:0] t_value;

    localparam logic [MODE_W-1:0] MODE_FIRST  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SECOND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FINISH = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        t_value            value;
    } t_req;

    typedef struct packed {
        t_value common_value;
        logic   last;
        logic   empty_res;
        logic   overflow;
    } t_res;

    typedef struct packed {
        logic   insert;
        logic   pop;
        logic   clear;
        t_value x;
    } t_chain_cmd;

    typedef struct packed {
        t_value head;
        logic   nonempty;
        logic   full;
    } t_chain_stat;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_MERGE
    } t_state;

endpackage

`default_nettype wire

/* rtl/core/smi_cell.sv */
// One cell of a sorting chain: holds one element and either keeps it, takes
// the inserted element, or takes a neighbor's element. Depends on smi_pkg.
`default_nettype none

module smi_cell
    import smi_pkg::*;
(
    input  wire         i_clk,
    input  t_chain_cmd  i_cmd,
    input  wire         i_occ,
    input  wire         i_prev_keep,
    input  t_value      i_prev_val,
    input  t_value      i_next_val,
    output t_value      o_val,
    output logic        o_keep
);

    t_value r_val;
    t_value n_val;

    // An occupied cell whose element does not exceed the new one stays put.
    assign o_keep = i_occ && (r_val <= i_cmd.x);
    assign o_val  = r_val;

    always_comb begin
        n_val = r_val;
        if (i_cmd.insert) begin
            if (!o_keep) begin
                n_val = i_prev_keep ? i_cmd.x : i_prev_val;
            end
        end else if (i_cmd.pop) begin
            n_val = i_next_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

`default_nettype wire

/* rtl/core/smi_chain.sv */
// A row of sorting cells that keeps one multiset in ascending order, with
// its fill count. Depends on smi_pkg and smi_cell.
`default_nettype none

module smi_chain
    import smi_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  t_chain_cmd   i_cmd,
    output t_chain_stat  o_stat
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          full;
    logic          nonempty;
    t_chain_cmd    cell_cmd;
    t_value        vals  [DEPTH];
    logic          keeps [DEPTH];

    assign full     = (r_count == CW'(DEPTH));
    assign nonempty = (r_count != '0);

    // A full chain ignores an insert; a pop of an empty chain does nothing.
    always_comb begin
        cell_cmd        = i_cmd;
        cell_cmd.insert = i_cmd.insert && !full;
        cell_cmd.pop    = i_cmd.pop && nonempty;
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        smi_cell u_cell (
            .i_clk       (i_clk),
            .i_cmd       (cell_cmd),
            .i_occ       (r_count > CW'(g)),
            .i_prev_keep ((g == 0) ? 1'b1 : keeps[(g == 0) ? 0 : g - 1]),
            .i_prev_val  (vals[(g == 0) ? 0 : g - 1]),
            .i_next_val  (vals[(g == DEPTH - 1) ? g : g + 1]),
            .o_val       (vals[g]),
            .o_keep      (keeps[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.clear) begin
            n_count = '0;
        end else if (cell_cmd.insert) begin
            n_count = r_count + CW'(1);
        end else if (cell_cmd.pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_stat.head     = vals[0];
    assign o_stat.nonempty = nonempty;
    assign o_stat.full     = full;

endmodule

`default_nettype wire

/* rtl/core/sorted_multiset_intersection_core.sv */
// Top level of the sorted multiset intersection core: two sorting chains
// and the merge sequencer. Depends on smi_pkg and smi_chain.
`default_nettype none

// The core collects two multisets of signed values and, on a finish request,
// emits their intersection in ascending order, each common value as often as
// the smaller of its two multiplicities. A load request (mode first or
// second) does not raise busy: each chain of cells keeps its elements sorted
// as they arrive, so a load can be issued every cycle while busy is low. A
// load into a full chain is dropped and sets the overflow flag reported on
// every result of the next finish. A finish request raises busy while the
// merge walks both chains, popping one or both heads per cycle. Busy stays
// high until one chain is empty, which ends the merge at once if a chain was
// empty at the finish, and falls in the same cycle in which the final result
// comes out. Each result appears on o_res marked by o_strobe, high for a
// single cycle, and results cannot be held off; the final result has last
// set, and a finish with nothing in common gives one result with empty_res
// set and common_value zero. Mode 3 is ignored. After a finish both chains
// and the overflow flag are empty again.
module sorted_multiset_intersection_core
    import smi_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   start,
    input  t_req  i_req,
    output logic  busy,
    output logic  o_strobe,
    output t_res  o_res
);

    t_state      r_state;
    t_state      n_state;
    logic        r_drop;
    logic        n_drop;
    logic        r_pend_v;
    logic        n_pend_v;
    t_value      r_pend;
    t_value      n_pend;
    logic        r_strobe;
    logic        n_strobe;
    t_res        r_res;
    t_res        n_res;
    t_chain_cmd  cmd_a;
    t_chain_cmd  cmd_b;
    t_chain_stat stat_a;
    t_chain_stat stat_b;
    logic        accept;

    assign accept = start && (r_state == ST_IDLE);

    smi_chain #(.DEPTH(DEPTH)) u_chain_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_a),
        .o_stat  (stat_a)
    );

    smi_chain #(.DEPTH(DEPTH)) u_chain_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_b),
        .o_stat  (stat_b)
    );

    // The merge holds each match back until the next match comes, so that when
    // the chains run dry the held match can go out with last set.
    always_comb begin
        n_state  = r_state;
        n_drop   = r_drop;
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        n_strobe = 1'b0;
        n_res    = r_res;
        cmd_a    = '{insert: 1'b0, pop: 1'b0, clear: 1'b0, x: i_req.value};
        cmd_b    = '{insert: 1'b0, pop: 1'b0, clear: 1'b0, x: i_req.value};
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_req.mode)
                        MODE_FIRST: begin
                            cmd_a.insert = 1'b1;
                            if (stat_a.full) begin
                                n_drop = 1'b1;
                            end
                        end
                        MODE_SECOND: begin
                            cmd_b.insert = 1'b1;
                            if (stat_b.full) begin
                                n_drop = 1'b1;
                            end
                        end
                        MODE_FINISH: begin
                            n_state  = ST_MERGE;
                            n_pend_v = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_MERGE: begin
                if (stat_a.nonempty && stat_b.nonempty) begin
                    if (stat_a.head == stat_b.head) begin
                        cmd_a.pop = 1'b1;
                        cmd_b.pop = 1'b1;
                        n_pend_v  = 1'b1;
                        n_pend    = stat_a.head;
                        if (r_pend_v) begin
                            n_strobe = 1'b1;
                            n_res    = '{common_value: r_pend, last: 1'b0,
                                         empty_res: 1'b0, overflow: r_drop};
                        end
                    end else if (stat_a.head < stat_b.head) begin
                        cmd_a.pop = 1'b1;
                    end else begin
                        cmd_b.pop = 1'b1;
                    end
                end else begin
                    // One chain is exhausted: close out this finish.
                    n_strobe    = 1'b1;
                    n_res       = '{common_value: r_pend_v ? r_pend : '0, last: 1'b1,
                                    empty_res: !r_pend_v, overflow: r_drop};
                    cmd_a.clear = 1'b1;
                    cmd_b.clear = 1'b1;
                    n_drop      = 1'b0;
                    n_pend_v    = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_drop   <= 1'b0;
            r_pend_v <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_drop   <= n_drop;
            r_pend_v <= n_pend_v;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_res  <= n_res;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

`default_nettype wire
